@@ hw/rtl/rarp_pkg.sv @@
// ----------------------------------------------------------------------------
// RARP responder package
// Shared constants, register indexes, payload types and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rarp_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;

  localparam logic [10:0] MIN_FRAME_LEN   = 11'd60;
  localparam logic [15:0] HW_ETHERNET     = 16'd1;
  localparam logic [15:0] PROTO_IPV4      = 16'h0800;
  localparam logic [7:0]  HW_ADDR_LEN     = 8'd6;
  localparam logic [7:0]  PROTO_ADDR_LEN  = 8'd4;
  localparam logic [15:0] OP_ARP_REPLY    = 16'd2;
  localparam logic [15:0] OP_RARP_REQUEST = 16'd3;
  localparam logic [15:0] OP_RARP_REPLY   = 16'd4;
  localparam logic        KIND_RARP       = 1'b0;
  localparam logic        KIND_ARP        = 1'b1;
  localparam logic        MODE_LOAD       = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_MAC    = 3'd0,
    REG_OWN_IP     = 3'd1,
    REG_NET_MASK   = 3'd2,
    REG_NET_PREFIX = 3'd3,
    REG_ARP_ALSO   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic        mode;
    logic [10:0] frame_length;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [47:0] target_mac;
    logic [47:0] entry_mac;
    logic [31:0] entry_ip;
  } in_item_t;

  typedef struct packed {
    logic        reply_kind;
    logic [47:0] dest_mac;
    logic [15:0] reply_opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [47:0] answer_mac;
    logic [31:0] answer_ip;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic load_entry;
    logic start_scan;
    logic scan;
    logic load_rarp;
    logic load_arp;
  } dp_cmd_t;

  typedef struct packed {
    logic is_load;
    logic req_ok;
    logic hit;
    logic pass;
    logic exhausted;
    logic arp_also;
  } dp_status_t;

endpackage

@@ hw/rtl/rarp_ifs.sv @@
// ----------------------------------------------------------------------------
// RARP responder channel interfaces
// Valid/ready channels for request items, reply items and register writes.
// ----------------------------------------------------------------------------
interface rarp_in_if;
  logic               valid;
  logic               ready;
  rarp_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface rarp_out_if;
  logic                valid;
  logic                ready;
  rarp_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface rarp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [rarp_pkg::CFG_IDX_W-1:0]      index;
  logic [rarp_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/rarp_ctrl.sv @@
// ----------------------------------------------------------------------------
// RARP responder controller
// Sequences table loads, the table scan and the delivery of up to two
// replies per accepted request.
// ----------------------------------------------------------------------------
module rarp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  rarp_pkg::dp_status_t st,
  output rarp_pkg::dp_cmd_t    cmd
);
  import rarp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'b0001,
    ST_SCAN      = 4'b0010,
    ST_SEND_RARP = 4'b0100,
    ST_SEND_ARP  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (st.is_load) begin
            cmd.load_entry = 1'b1;
          end else if (st.req_ok) begin
            cmd.start_scan = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.hit) begin
          if (st.pass) begin
            cmd.load_rarp = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_SEND_RARP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (st.exhausted) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SEND_RARP: begin
        if (out_ready) begin
          if (st.arp_also) begin
            cmd.load_arp = 1'b1;
            state_nxt    = ST_SEND_ARP;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_SEND_ARP: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
        state_nxt     = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input accepted while a reply is pending");

  a_hit_gives_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && st.hit && st.pass |=> out_valid)
    else $error("passing table hit did not raise a reply");

  a_miss_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && st.exhausted && !st.hit |=> in_ready)
    else $error("exhausted scan did not return to idle");

  a_arp_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND_ARP) && out_ready |=> in_ready && !out_valid)
    else $error("final reply transaction did not end the request");
`endif

endmodule

@@ hw/rtl/rarp_dp.sv @@
// ----------------------------------------------------------------------------
// RARP responder datapath
// Holds the registers, the address table memory, the scan index with its
// registered read, the header and subnet checks and the reply register.
// ----------------------------------------------------------------------------
module rarp_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rarp_pkg::in_item_t                  in_item,
  output rarp_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [rarp_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [rarp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  rarp_pkg::dp_cmd_t                   cmd,
  output rarp_pkg::dp_status_t                st
);
  import rarp_pkg::*;

  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r;
  logic [31:0] net_mask_r;
  logic [31:0] net_prefix_r;
  logic        arp_also_r;

  logic [47:0] mac_mem [TABLE_DEPTH];
  logic [31:0] ip_mem  [TABLE_DEPTH];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             rd_vld_r;
  logic             rd_last_r;
  logic [47:0]      rd_mac_r;
  logic [31:0]      rd_ip_r;
  logic [47:0]      target_r;
  logic [31:0]      found_ip_r;
  out_item_t        out_r;

  logic full;
  logic issue;
  logic hdr_ok;
  logic match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r    <= '0;
      own_ip_r     <= '0;
      net_mask_r   <= '0;
      net_prefix_r <= '0;
      arp_also_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_OWN_MAC:    own_mac_r    <= cfg_data;
        REG_OWN_IP:     own_ip_r     <= cfg_data[31:0];
        REG_NET_MASK:   net_mask_r   <= cfg_data[31:0];
        REG_NET_PREFIX: net_prefix_r <= cfg_data[31:0];
        REG_ARP_ALSO:   arp_also_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign full  = (count_r == CNT_W'(TABLE_DEPTH));
  assign issue = cmd.scan && (idx_r < count_r);

  always_comb begin
    count_nxt = count_r;
    if (cmd.load_entry && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
    idx_nxt = idx_r;
    if (cmd.start_scan) begin
      idx_nxt = '0;
    end else if (issue) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      rd_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_entry && !full) begin
      mac_mem[count_r[ADDR_W-1:0]] <= in_item.entry_mac;
      ip_mem[count_r[ADDR_W-1:0]]  <= in_item.entry_ip;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_mac_r  <= mac_mem[idx_r[ADDR_W-1:0]];
      rd_ip_r   <= ip_mem[idx_r[ADDR_W-1:0]];
      rd_last_r <= ((idx_r + CNT_W'(1)) == count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_scan) begin
      target_r <= in_item.target_mac;
    end
    if (cmd.load_rarp) begin
      found_ip_r         <= rd_ip_r;
      out_r.reply_kind   <= KIND_RARP;
      out_r.dest_mac     <= target_r;
      out_r.reply_opcode <= OP_RARP_REPLY;
      out_r.sender_mac   <= own_mac_r;
      out_r.sender_ip    <= own_ip_r;
      out_r.answer_mac   <= target_r;
      out_r.answer_ip    <= rd_ip_r;
      out_r.last         <= !arp_also_r;
    end else if (cmd.load_arp) begin
      out_r.reply_kind   <= KIND_ARP;
      out_r.dest_mac     <= own_mac_r;
      out_r.reply_opcode <= OP_ARP_REPLY;
      out_r.sender_mac   <= target_r;
      out_r.sender_ip    <= found_ip_r;
      out_r.answer_mac   <= own_mac_r;
      out_r.answer_ip    <= own_ip_r;
      out_r.last         <= 1'b1;
    end
  end

  assign hdr_ok = (in_item.frame_length >= MIN_FRAME_LEN) &&
                  (in_item.hw_type == HW_ETHERNET) &&
                  (in_item.proto_type == PROTO_IPV4) &&
                  (in_item.hw_len == HW_ADDR_LEN) &&
                  (in_item.proto_len == PROTO_ADDR_LEN) &&
                  (in_item.opcode == OP_RARP_REQUEST);

  assign match = rd_vld_r && (rd_mac_r == target_r);

  assign st.is_load   = (in_item.mode == MODE_LOAD);
  assign st.req_ok    = hdr_ok && (count_r != '0);
  assign st.hit       = match;
  assign st.pass      = ((rd_ip_r & net_mask_r) == net_prefix_r);
  assign st.exhausted = rd_vld_r && rd_last_r && !match;
  assign st.arp_also  = arp_also_r;

  assign out_item = out_r;

endmodule

@@ hw/rtl/rarp_request_responder.sv @@
// ----------------------------------------------------------------------------
// RARP request responder
// Answers reverse-address requests from a loaded table of hardware-to-IP
// pairs with a RARP reply and an optional ARP reply.
// ----------------------------------------------------------------------------
// A load transaction is accepted while idle. A request is accepted while idle,
// then scans the table one entry per cycle until a hit or the last loaded
// entry, bounded by the single table read port.
// Replies then leave through an output register, one per cycle when taken.
// Synchronous reset empties the table, clears the registers (arp_also to 1)
// and returns to idle; register writes are taken in every cycle.
module rarp_request_responder (
  input logic       clk,
  input logic       rst_n,
  rarp_in_if.sink   in_bus,
  rarp_out_if.source out_bus,
  rarp_cfg_if.sink  cfg_bus
);
  import rarp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_bus.ready = 1'b1;

  rarp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .st        (st),
    .cmd       (cmd)
  );

  rarp_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_bus.item),
    .out_item (out_bus.item),
    .cfg_we   (cfg_bus.valid && cfg_bus.ready),
    .cfg_idx  (cfg_bus.index),
    .cfg_data (cfg_bus.data),
    .cmd      (cmd),
    .st       (st)
  );

endmodule

@@ tb/rarp_request_responder_test.sv @@
// ----------------------------------------------------------------------------
// RARP request responder testbench
// Loads the address table and sends well-formed, malformed and noise
// requests under several register settings and flow-control mixes. Each
// accepted transaction is run through a local predictor, and every reply
// is compared field by field with the oldest predicted reply.
// ----------------------------------------------------------------------------
module rarp_request_responder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rarp_pkg::*;

  localparam logic        MODE_REQUEST     = 1'b1;
  localparam logic [10:0] MAX_FRAME_LEN    = 11'd1514;
  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = CFG_IDX_W'(REG_ARP_ALSO + 1);
  localparam int          RANDOM_PHASES    = 8;
  localparam int          PHASE_ITEMS      = 200;
  localparam int          SETTLE_CYCLES    = 300;
  localparam int          QUIET_LIMIT      = 5000;

  logic clk;
  logic rst_n;

  rarp_in_if  in_ch ();
  rarp_out_if out_ch ();
  rarp_cfg_if cfg_ch ();

  rarp_request_responder u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .cfg_bus (cfg_ch)
  );

  // Register and table state as the predictor sees it.
  logic [47:0] cfg_own_mac;
  logic [31:0] cfg_own_ip;
  logic [31:0] cfg_net_mask;
  logic [31:0] cfg_net_prefix;
  logic        cfg_arp_also;
  logic [47:0] lut_mac [TABLE_DEPTH];
  logic [31:0] lut_ip  [TABLE_DEPTH];
  int          lut_count;

  in_item_t    pending_q [$];
  out_item_t   reply_q   [$];
  int          pushed_cnt;
  int          accepted_cnt;
  int          fail_count;
  int          quiet_cycles;
  int          send_idle_pct;
  int          stall_pct;

  // Stimulus bookkeeping: addresses handed to the table so far.
  logic [47:0] gen_macs [$];
  logic [31:0] gen_ips  [$];
  int          gen_loads;
  logic [15:0] subnets [4];

  always #5 clk = ~clk;

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic void predict_replies(in_item_t it);
    logic [31:0] found;
    bit          hit;
    out_item_t   rep;
    hit = 1'b0;
    found = '0;
    if (it.mode == MODE_LOAD) begin
      if (lut_count < TABLE_DEPTH) begin
        lut_mac[lut_count] = it.entry_mac;
        lut_ip[lut_count]  = it.entry_ip;
        lut_count++;
      end
      return;
    end
    if (it.frame_length < MIN_FRAME_LEN || it.hw_type != HW_ETHERNET ||
        it.proto_type != PROTO_IPV4 || it.hw_len != HW_ADDR_LEN ||
        it.proto_len != PROTO_ADDR_LEN || it.opcode != OP_RARP_REQUEST)
      return;
    for (int i = 0; i < lut_count; i++) begin
      if (lut_mac[i] == it.target_mac) begin
        found = lut_ip[i];
        hit = 1'b1;
        break;
      end
    end
    if (!hit || (found & cfg_net_mask) != cfg_net_prefix) return;
    rep.reply_kind   = KIND_RARP;
    rep.dest_mac     = it.target_mac;
    rep.reply_opcode = OP_RARP_REPLY;
    rep.sender_mac   = cfg_own_mac;
    rep.sender_ip    = cfg_own_ip;
    rep.answer_mac   = it.target_mac;
    rep.answer_ip    = found;
    rep.last         = !cfg_arp_also;
    reply_q.push_back(rep);
    if (!cfg_arp_also) return;
    rep.reply_kind   = KIND_ARP;
    rep.dest_mac     = cfg_own_mac;
    rep.reply_opcode = OP_ARP_REPLY;
    rep.sender_mac   = it.target_mac;
    rep.sender_ip    = found;
    rep.answer_mac   = cfg_own_mac;
    rep.answer_ip    = cfg_own_ip;
    rep.last         = 1'b1;
    reply_q.push_back(rep);
  endfunction

  function automatic void field_check(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_reply(out_item_t got);
    out_item_t want;
    if (reply_q.size() == 0) begin
      $display("%0t: unexpected reply: expected none, actual %p", $time, got);
      fail_count++;
      return;
    end
    want = reply_q.pop_front();
    field_check("reply_kind", 64'(want.reply_kind), 64'(got.reply_kind));
    field_check("dest_mac", 64'(want.dest_mac), 64'(got.dest_mac));
    field_check("reply_opcode", 64'(want.reply_opcode), 64'(got.reply_opcode));
    field_check("sender_mac", 64'(want.sender_mac), 64'(got.sender_mac));
    field_check("sender_ip", 64'(want.sender_ip), 64'(got.sender_ip));
    field_check("answer_mac", 64'(want.answer_mac), 64'(got.answer_mac));
    field_check("answer_ip", 64'(want.answer_ip), 64'(got.answer_ip));
    field_check("last", 64'(want.last), 64'(got.last));
  endfunction

  always @(posedge clk) begin : drive_requests
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_replies(in_ch.item);
        accepted_cnt++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.item  <= pending_q.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_replies
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_reply(out_ch.item);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_OWN_MAC:    cfg_own_mac    = data[47:0];
      REG_OWN_IP:     cfg_own_ip     = data[31:0];
      REG_NET_MASK:   cfg_net_mask   = data[31:0];
      REG_NET_PREFIX: cfg_net_prefix = data[31:0];
      REG_ARP_ALSO:   cfg_arp_also   = data[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [47:0] mac, logic [31:0] ip, logic [31:0] mask,
                              logic [31:0] prefix, logic arp);
    write_reg(REG_OWN_MAC, mac);
    write_reg(REG_OWN_IP, {16'($urandom), ip});
    write_reg(REG_NET_MASK, {16'($urandom), mask});
    write_reg(REG_NET_PREFIX, {16'($urandom), prefix});
    write_reg(REG_ARP_ALSO, {47'(rand48()), arp});
    write_reg(CFG_IDX_W'(FIRST_UNUSED_REG + $urandom_range(0, 2)), rand48());
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic in_item_t random_item();
    in_item_t     it;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic in_item_t make_request(logic [47:0] target);
    in_item_t it;
    it = random_item();
    it.mode         = MODE_REQUEST;
    it.frame_length = 11'($urandom_range(MIN_FRAME_LEN, MAX_FRAME_LEN));
    it.hw_type      = HW_ETHERNET;
    it.proto_type   = PROTO_IPV4;
    it.hw_len       = HW_ADDR_LEN;
    it.proto_len    = PROTO_ADDR_LEN;
    it.opcode       = OP_RARP_REQUEST;
    it.target_mac   = target;
    return it;
  endfunction

  function automatic void queue_item(in_item_t it);
    pending_q.push_back(it);
    pushed_cnt++;
  endfunction

  function automatic void queue_load(logic [47:0] mac, logic [31:0] ip);
    in_item_t it;
    it = random_item();
    it.mode      = MODE_LOAD;
    it.entry_mac = mac;
    it.entry_ip  = ip;
    queue_item(it);
    if (gen_loads < TABLE_DEPTH) begin
      gen_macs.push_back(mac);
      gen_ips.push_back(ip);
    end
    gen_loads++;
  endfunction

  function automatic logic [47:0] known_mac();
    return gen_macs[$urandom_range(0, gen_macs.size() - 1)];
  endfunction

  // Returns 0 for a load into a full table, which the block simply drops.
  function automatic bit queue_random_item();
    in_item_t    it;
    logic [47:0] mac;
    logic [31:0] ip;
    if ($urandom_range(0, 99) < ((gen_loads < TABLE_DEPTH) ? 30 : 3)) begin
      mac = ($urandom_range(0, 99) < 15) ? known_mac() : rand48();
      ip  = ($urandom_range(0, 99) < 80) ? {subnets[$urandom_range(0, 3)], 16'($urandom)}
                                         : 32'($urandom);
      queue_random_item = (gen_loads < TABLE_DEPTH);
      queue_load(mac, ip);
      return queue_random_item;
    end
    it = make_request(($urandom_range(0, 99) < 75) ? known_mac() : rand48());
    if ($urandom_range(0, 99) >= 72) begin
      case ($urandom_range(0, 6))
        0: it.frame_length = 11'($urandom_range(0, MIN_FRAME_LEN - 1));
        1: it.hw_type = 16'($urandom);
        2: it.proto_type = 16'($urandom);
        3: it.hw_len = 8'($urandom);
        4: it.proto_len = 8'($urandom);
        5: it.opcode = $urandom_range(0, 1) ? OP_ARP_REPLY : 16'($urandom);
        default: begin
          it = random_item();
          it.mode = MODE_REQUEST;
        end
      endcase
    end
    queue_item(it);
    return 1;
  endfunction

  task automatic drain();
    while (accepted_cnt != pushed_cnt) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic setup_phase(int p);
    logic [47:0] mac;
    logic [31:0] ip;
    logic [31:0] mask;
    logic [31:0] prefix;
    logic        arp;
    mac = (p == 0) ? '0 : (p == 1) ? '1 : rand48();
    ip  = (p == 1) ? '0 : (p == 2) ? '1 : 32'($urandom);
    case (p)
      0: begin mask = '0; prefix = '0; arp = 1'b1; end
      1: begin mask = 32'hFFFF_0000; prefix = {subnets[0], 16'h0}; arp = 1'b0; end
      2: begin mask = '1; prefix = gen_ips[$urandom_range(0, gen_ips.size() - 1)]; arp = 1'b1; end
      3: begin mask = 32'hFF00_0000; prefix = 32'h0000_0001; arp = 1'b1; end
      4: begin mask = 32'hFFFF_0000; prefix = {subnets[1], 16'h0}; arp = 1'b1; end
      5: begin mask = '0; prefix = '0; arp = 1'b0; end
      6: begin mask = '0; prefix = $urandom | 32'h1; arp = 1'b0; end
      default: begin mask = 32'hFFFF_0000; prefix = {subnets[2], 16'h0}; arp = 1'b1; end
    endcase
    program_regs(mac, ip, mask, prefix, arp);
    case (p % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 58; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 58; end
      default: begin send_idle_pct = 19; stall_pct = 19; end
    endcase
  endtask

  initial begin
    in_item_t    it;
    logic [47:0] mac_a;
    int          counted;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.item = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    cfg_own_mac = '0;
    cfg_own_ip = '0;
    cfg_net_mask = '0;
    cfg_net_prefix = '0;
    cfg_arp_also = 1'b1;
    lut_count = 0;
    pushed_cnt = 0;
    accepted_cnt = 0;
    fail_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    gen_loads = 0;
    foreach (subnets[i]) subnets[i] = 16'($urandom);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: address extremes, a duplicate entry, every header check.
    program_regs(rand48(), $urandom, '0, '0, 1'b1);
    mac_a = rand48();
    queue_load('0, '0);
    queue_load('1, '1);
    queue_load(mac_a, $urandom);
    queue_load(mac_a, $urandom);
    queue_item(make_request(mac_a));
    queue_item(make_request('0));
    it = make_request('1);
    it.frame_length = MAX_FRAME_LEN;
    queue_item(it);
    it = make_request(mac_a);
    it.frame_length = MIN_FRAME_LEN - 1;
    queue_item(it);
    it.frame_length = MIN_FRAME_LEN;
    queue_item(it);
    it.frame_length = '0;
    queue_item(it);
    it = make_request(mac_a);
    it.hw_type = '0;
    queue_item(it);
    it.hw_type = '1;
    queue_item(it);
    it = make_request(mac_a);
    it.proto_type = '1;
    queue_item(it);
    it.proto_type = '0;
    queue_item(it);
    it = make_request(mac_a);
    it.hw_len = '1;
    queue_item(it);
    it = make_request(mac_a);
    it.proto_len = '0;
    queue_item(it);
    it = make_request(mac_a);
    it.opcode = OP_ARP_REPLY;
    queue_item(it);
    it.opcode = OP_RARP_REPLY;
    queue_item(it);
    it.opcode = '1;
    queue_item(it);
    queue_item(make_request(rand48()));
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      setup_phase(p);
      counted = 0;
      while (counted < PHASE_ITEMS) counted += queue_random_item();
      drain();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
